FILE: rtl/bf16_add_truncating_core_assert.svh
// ----------------------------------------------------------------------------
// bf16_add_truncating_core_assert.svh
// assertion macros for the port-level checker file
// ----------------------------------------------------------------------------
`ifndef BF16_ADD_TRUNCATING_CORE_ASSERT_SVH
`define BF16_ADD_TRUNCATING_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BF16A_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bf16 adder check failed");

// next-cycle implication, disabled during reset
`define BF16A_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bf16 adder check failed");

`endif

FILE: rtl/bf16a_pkg.sv
// ----------------------------------------------------------------------------
// bf16a_pkg
// types and constants for the bfloat16 truncating adder pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bf16a_pkg;

   localparam int ALIGN_SHIFT = 30;
   localparam int SMALL_W     = ALIGN_SHIFT + 8;
   localparam int SUM_W       = ALIGN_SHIFT + 9;

   localparam logic [15:0] BF_NAN = 16'h7FC0;
   localparam logic [14:0] BF_INF = 15'h7F80;

   // operands ordered and aligned
   typedef struct packed {
      logic                special;
      logic [15:0]         spec_bits;
      logic                sign;
      logic                zsign;
      logic                eff_sub;
      logic [7:0]          e_big;
      logic [7:0]          big_man;
      logic [SMALL_W-1:0]  small_man;
      logic                last;
   } align_type;

   // raw sum
   typedef struct packed {
      logic                special;
      logic [15:0]         spec_bits;
      logic                sign;
      logic [7:0]          e_big;
      logic [SUM_W-1:0]    r;
      logic                last;
   } sum_type;

   // leading one located, exponent and shift worked out
   typedef struct packed {
      logic                special;
      logic [15:0]         spec_bits;
      logic                sign;
      logic signed [9:0]   expo;
      logic signed [6:0]   shift;
      logic [SUM_W-1:0]    r;
      logic                last;
   } norm_type;

   // final result
   typedef struct packed {
      logic [15:0]         sum_bits;
      logic                last;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/bf16a_align_stage.sv
// ----------------------------------------------------------------------------
// bf16a_align_stage
// unpack, special cases, magnitude ordering and alignment of the smaller operand
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bf16a_align_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 up_valid,
   output logic                      up_ready,
   input  wire logic [15:0]          in_value,
   input  wire logic [15:0]          acc_value,
   input  wire logic                 last_in,
   output logic                      dn_valid,
   input  wire logic                 dn_ready,
   output bf16a_pkg::align_type      dn_data
);

   logic                  valid_ff;
   bf16a_pkg::align_type  data_ff, data_in;

   logic        sa, sb, nan_a, nan_b, inf_a, inf_b, swap;
   logic [7:0]  ea, eb, ea1, eb1, fa8, fb8, ma, mb, d;
   logic [bf16a_pkg::SMALL_W-1:0] full, low_mask;

   // unpack and order
   always_comb begin
      sa    = in_value[15];
      sb    = acc_value[15];
      ea    = in_value[14:7];
      eb    = acc_value[14:7];
      fa8   = {1'b0, in_value[6:0]};
      fb8   = {1'b0, acc_value[6:0]};
      nan_a = (ea == 8'hFF) && (fa8 != 8'd0);
      nan_b = (eb == 8'hFF) && (fb8 != 8'd0);
      inf_a = (ea == 8'hFF) && (fa8 == 8'd0);
      inf_b = (eb == 8'hFF) && (fb8 == 8'd0);
      ma    = (ea == 8'd0) ? fa8 : (fa8 | 8'h80);
      mb    = (eb == 8'd0) ? fb8 : (fb8 | 8'h80);
      ea1   = (ea == 8'd0) ? 8'd1 : ea;
      eb1   = (eb == 8'd0) ? 8'd1 : eb;
      swap  = (ea1 < eb1) || ((ea1 == eb1) && (ma < mb));

      data_in           = '0;
      data_in.last      = last_in;
      data_in.eff_sub   = sa ^ sb;
      data_in.zsign     = sa & sb;
      data_in.sign      = swap ? sb : sa;
      data_in.e_big     = swap ? eb1 : ea1;
      data_in.big_man   = swap ? mb : ma;
      d                 = swap ? (eb1 - ea1) : (ea1 - eb1);
      full              = {(swap ? ma : mb), {bf16a_pkg::ALIGN_SHIFT{1'b0}}};
      low_mask          = '0;

      // shift the smaller mantissa right with a sticky bit
      if (d > 8'd38) begin
         data_in.small_man = {{(bf16a_pkg::SMALL_W-1){1'b0}}, (full != '0)};
      end else begin
         low_mask          = ({{(bf16a_pkg::SMALL_W-1){1'b0}}, 1'b1} << d)
                             - {{(bf16a_pkg::SMALL_W-1){1'b0}}, 1'b1};
         data_in.small_man = (full >> d)
                             | {{(bf16a_pkg::SMALL_W-1){1'b0}}, ((full & low_mask) != '0)};
      end

      // nan and infinity operands
      data_in.special   = nan_a | nan_b | inf_a | inf_b;
      if (nan_a || nan_b) begin
         data_in.spec_bits = bf16a_pkg::BF_NAN;
      end else if (inf_a && inf_b) begin
         data_in.spec_bits = (sa != sb) ? bf16a_pkg::BF_NAN : {sa, bf16a_pkg::BF_INF};
      end else if (inf_a) begin
         data_in.spec_bits = {sa, bf16a_pkg::BF_INF};
      end else begin
         data_in.spec_bits = {sb, bf16a_pkg::BF_INF};
      end
   end

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/bf16a_add_stage.sv
// ----------------------------------------------------------------------------
// bf16a_add_stage
// mantissa add or subtract and exact cancellation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bf16a_add_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 up_valid,
   output logic                      up_ready,
   input  wire bf16a_pkg::align_type up_data,
   output logic                      dn_valid,
   input  wire logic                 dn_ready,
   output bf16a_pkg::sum_type        dn_data
);

   logic                     valid_ff;
   bf16a_pkg::sum_type       data_ff, data_in;
   logic [bf16a_pkg::SUM_W-1:0] big, small_ext;

   // add or subtract aligned mantissas
   always_comb begin
      big       = {1'b0, up_data.big_man, {bf16a_pkg::ALIGN_SHIFT{1'b0}}};
      small_ext = {1'b0, up_data.small_man};
      data_in.last      = up_data.last;
      data_in.sign      = up_data.sign;
      data_in.e_big     = up_data.e_big;
      data_in.r         = up_data.eff_sub ? (big - small_ext) : (big + small_ext);
      data_in.special   = up_data.special;
      data_in.spec_bits = up_data.spec_bits;
      // exact zero keeps the sign only when both were negative
      if (!up_data.special && (data_in.r == '0)) begin
         data_in.special   = 1'b1;
         data_in.spec_bits = {up_data.zsign, 15'd0};
      end
   end

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/bf16a_lzc_stage.sv
// ----------------------------------------------------------------------------
// bf16a_lzc_stage
// leading one search, result exponent and rounding shift
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bf16a_lzc_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               up_valid,
   output logic                    up_ready,
   input  wire bf16a_pkg::sum_type up_data,
   output logic                    dn_valid,
   input  wire logic               dn_ready,
   output bf16a_pkg::norm_type     dn_data
);

   logic                 valid_ff;
   bf16a_pkg::norm_type  data_ff, data_in;
   logic [5:0]           p;
   logic signed [9:0]    expo;

   // priority encoder over the raw sum
   always_comb begin
      p = '0;
      for (int i = 0; i < bf16a_pkg::SUM_W; i++) begin
         if (up_data.r[i]) begin
            p = 6'(i);
         end
      end
      expo = $signed({4'd0, p}) + $signed({2'd0, up_data.e_big}) - 10'sd37;
      data_in.last      = up_data.last;
      data_in.sign      = up_data.sign;
      data_in.special   = up_data.special;
      data_in.spec_bits = up_data.spec_bits;
      data_in.r         = up_data.r;
      data_in.expo      = expo;
      // normal results keep 24 bits, subnormals shift to the fixed scale
      if (expo >= 10'sd1) begin
         data_in.shift = 7'($signed({4'd0, p}) - 10'sd23);
      end else begin
         data_in.shift = 7'(10'sd15 - $signed({2'd0, up_data.e_big}));
      end
   end

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/bf16a_round_stage.sv
// ----------------------------------------------------------------------------
// bf16a_round_stage
// fp32 round to nearest even, overflow, pack and truncate to bfloat16
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bf16a_round_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                up_valid,
   output logic                     up_ready,
   input  wire bf16a_pkg::norm_type up_data,
   output logic                     dn_valid,
   input  wire logic                dn_ready,
   output bf16a_pkg::result_type    dn_data
);

   logic                   valid_ff;
   bf16a_pkg::result_type  data_ff, data_in;
   logic [5:0]             sh;
   logic [bf16a_pkg::SUM_W-1:0] one, m, half_bit, below_mask;
   logic                   guard, sticky;
   logic [31:0]            bits;

   always_comb begin
      one        = {{(bf16a_pkg::SUM_W-1){1'b0}}, 1'b1};
      sh         = up_data.shift[5:0];
      half_bit   = '0;
      below_mask = '0;
      guard      = 1'b0;
      sticky     = 1'b0;
      // shift into place and round to nearest even
      if (up_data.shift <= 7'sd0) begin
         m = up_data.r << (6'd0 - sh);
      end else begin
         m          = up_data.r >> sh;
         half_bit   = one << (sh - 6'd1);
         below_mask = half_bit - one;
         guard      = (up_data.r & half_bit) != '0;
         sticky     = (up_data.r & below_mask) != '0;
         if (guard && (sticky || m[0])) begin
            m = m + one;
         end
      end
      // pack with exponent, clamp overflow to infinity
      if (up_data.expo >= 10'sd1) begin
         bits = {1'b0, 8'(up_data.expo - 10'sd1), 23'd0} + m[31:0];
      end else begin
         bits = m[31:0];
      end
      if ((up_data.expo >= 10'sd255) || (bits >= 32'h7F800000)) begin
         bits = 32'h7F800000;
      end
      data_in.last = up_data.last;
      if (up_data.special) begin
         data_in.sum_bits = up_data.spec_bits;
      end else begin
         data_in.sum_bits = {up_data.sign, bits[30:16]};
      end
   end

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/bf16_add_truncating_core.sv
// ----------------------------------------------------------------------------
// bf16_add_truncating_core
// streaming bfloat16 adder, fp32 rounding then truncation to bfloat16
// ----------------------------------------------------------------------------
// Adds two bfloat16 words per beat as IEEE single precision (round to
// nearest even, subnormals kept) and returns the upper half of the sum; any
// NaN comes out as 0x7FC0 and tlast passes through. Four register stages
// (align, add, leading-one search, round and pack) lie between an accepted
// input beat and its result beat, and a new beat is taken every cycle while
// the result side does not stall. Each stage holds its own valid bit, so a
// stall on the result side only backs up once the stages ahead of it are
// full, and empty stages keep accepting.
`timescale 1ns / 1ps
`default_nettype none

module bf16_add_truncating_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // in_value[15:0], acc_value[31:16]
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // sum_bits[15:0]
   output logic             rsp_tlast
);

   logic                   v1, r1, v2, r2, v3, r3;
   bf16a_pkg::align_type   d1;
   bf16a_pkg::sum_type     d2;
   bf16a_pkg::norm_type    d3;
   bf16a_pkg::result_type  d4;

   bf16a_align_stage u_align (
      .clock(clock), .reset(reset),
      .up_valid(req_tvalid), .up_ready(req_tready),
      .in_value(req_tdata[15:0]), .acc_value(req_tdata[31:16]), .last_in(req_tlast),
      .dn_valid(v1), .dn_ready(r1), .dn_data(d1)
   );

   bf16a_add_stage u_add (
      .clock(clock), .reset(reset),
      .up_valid(v1), .up_ready(r1), .up_data(d1),
      .dn_valid(v2), .dn_ready(r2), .dn_data(d2)
   );

   bf16a_lzc_stage u_lzc (
      .clock(clock), .reset(reset),
      .up_valid(v2), .up_ready(r2), .up_data(d2),
      .dn_valid(v3), .dn_ready(r3), .dn_data(d3)
   );

   bf16a_round_stage u_round (
      .clock(clock), .reset(reset),
      .up_valid(v3), .up_ready(r3), .up_data(d3),
      .dn_valid(rsp_tvalid), .dn_ready(rsp_tready), .dn_data(d4)
   );

   assign rsp_tdata = d4.sum_bits;
   assign rsp_tlast = d4.last;

endmodule

`default_nettype wire

FILE: rtl/bf16a_checker.sv
// ----------------------------------------------------------------------------
// bf16a_checker
// port-level checks for the bfloat16 adder, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "bf16_add_truncating_core_assert.svh"

module bf16a_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [31:0] req_tdata,
   input  wire logic        req_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [15:0] rsp_tdata,
   input  wire logic        rsp_tlast
);

   // a stalled result beat holds
   `BF16A_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // with the output side free the pipeline always takes a beat
   `BF16A_ASSERT_NOW(a_ready_free, clock, reset, !rsp_tvalid || rsp_tready, req_tready)

   // every nan leaves as the canonical quiet nan
   `BF16A_ASSERT_NOW(a_nan_canon, clock, reset, rsp_tvalid && (rsp_tdata[14:7] == 8'hFF) && (rsp_tdata[6:0] != 7'd0), rsp_tdata == 16'h7FC0)

   // an offered request beat carries known data
   `BF16A_ASSERT_NOW(a_req_known, clock, reset, req_tvalid, !$isunknown({req_tdata, req_tlast}))

endmodule

bind bf16_add_truncating_core bf16a_checker u_bf16a_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready),
   .req_tdata(req_tdata), .req_tlast(req_tlast),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
);

`default_nettype wire
